// ===== rtl/ordered_array_insert_erase_top_macros.svh =====
// Assertion macros for the ordered array block.
`ifndef ORDERED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH
`define ORDERED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, muted during rst.
`define OAIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, muted during rst.
`define OAIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/oaie_pkg.sv =====
// Package: types, codes and size constants of the ordered array block.
package oaie_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int IDX_W     = 5;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_RESIZE = 3'd5,
    CMD_FRONT  = 3'd6,
    CMD_BACK   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic  en;
    cmd_t  op;
    word_t value;
  } cell_ctl_t;

endpackage

// ===== rtl/oaie_if.sv =====
// Handshake channels: command request and result response.
interface oaie_req_if;
  import oaie_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  command;
  logic  [IDX_W-1:0] index;
  word_t value;
  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

interface oaie_rsp_if;
  import oaie_pkg::*;
  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  logic    [CNT_OUT_W-1:0] count;
  logic    is_empty;
  modport source (output valid, read_value, status, count, is_empty, input ready);
  modport sink   (input valid, read_value, status, count, is_empty, output ready);
endinterface

// ===== rtl/oaie_cell.sv =====
// One storage cell of the chain: holds a word, shifts with its neighbors.
module oaie_cell #(
  parameter int POS = 0,
  parameter int W   = 5
) (
  input  logic               clk,
  input  oaie_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       idx,
  input  logic [W-1:0]       n,
  input  logic [W-1:0]       n_m1,
  input  oaie_pkg::word_t    left_word,
  input  oaie_pkg::word_t    right_word,
  output oaie_pkg::word_t    word,
  output oaie_pkg::word_t    rd_word
);
  import oaie_pkg::*;

  localparam logic [W-1:0] Pos = W'(POS);

  word_t word_next;
  logic  rd_hit;

  always_comb begin
    word_next = word;
    unique case (ctl.op)
      CMD_PUSH:   if (Pos == n) word_next = ctl.value;
      CMD_INSERT: begin
        if (Pos == idx) word_next = ctl.value;
        else if (Pos > idx) word_next = left_word;
      end
      CMD_ERASE:  if (Pos >= idx) word_next = right_word;
      CMD_WRITE:  if (Pos == idx) word_next = ctl.value;
      CMD_RESIZE: if (Pos >= n && Pos < idx) word_next = '0;
      CMD_READ, CMD_FRONT, CMD_BACK: word_next = word;
    endcase
  end

  always_comb begin
    unique case (ctl.op)
      CMD_READ:  rd_hit = (Pos == idx);
      CMD_FRONT: rd_hit = (Pos == '0);
      CMD_BACK:  rd_hit = (Pos == n_m1);
      default:   rd_hit = 1'b0;
    endcase
  end

  assign rd_word = rd_hit ? word : '0;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/ordered_array_insert_erase_top.sv =====
// Top level of the ordered array: command decode, fill count, cell chain, result register.
// Ordered array of DEPTH signed 32-bit words held in a chain of cells. Every command
// (push, insert, erase, read, write, resize, front, back) is seen by all cells at once:
// each cell picks its next word from itself, the request value, zero, or a neighbor, so
// insert and erase shift the whole tail together. One result per request transfer, held
// in an output register; a new request is taken every cycle while the response side
// keeps up, and the request side stalls only while a result waits unread. No clearing
// pass after reset: words are defined once push, insert, write or resize put them there.
module ordered_array_insert_erase_top #(
  parameter int DEPTH = oaie_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  oaie_req_if.sink   req,
  oaie_rsp_if.source rsp
);
  import oaie_pkg::*;

  // count width holds 0..DEPTH; compare width covers both count and index
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0] fill_count;

  logic          accept;
  logic [W-1:0]  idx_w;
  logic [W-1:0]  n_w;
  logic [W-1:0]  n_m1;
  logic [W-1:0]  cnt_next;
  status_t       status_c;
  cell_ctl_t     ctl;
  word_t         rd_or;
  word_t         read_value_c;

  word_t cell_word [DEPTH];
  word_t cell_rd   [DEPTH];

  // skid-free output register: take a request when the result slot is free or draining
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign idx_w = W'(req.index);
  assign n_w   = W'(fill_count);
  assign n_m1  = n_w - W'(1);

  // status and new count; failures leave the cells and fill count untouched
  always_comb begin
    status_c = ST_OK;
    cnt_next = n_w;
    unique case (req.command)
      CMD_PUSH: begin
        if (n_w >= W'(DEPTH)) status_c = ST_FULL;
        else cnt_next = n_w + W'(1);
      end
      CMD_INSERT: begin
        if (idx_w > n_w) status_c = ST_RANGE;
        else if (n_w >= W'(DEPTH)) status_c = ST_FULL;
        else cnt_next = n_w + W'(1);
      end
      CMD_ERASE: begin
        if (idx_w >= n_w) status_c = ST_RANGE;
        else cnt_next = n_m1;
      end
      CMD_READ, CMD_WRITE: begin
        if (idx_w >= n_w) status_c = ST_RANGE;
      end
      CMD_RESIZE: begin
        if (idx_w > W'(DEPTH)) status_c = ST_FULL;
        else cnt_next = idx_w;
      end
      CMD_FRONT, CMD_BACK: begin
        if (n_w == '0) status_c = ST_EMPTY;
      end
    endcase
  end

  assign ctl.en    = accept && (status_c == ST_OK);
  assign ctl.op    = req.command;
  assign ctl.value = req.value;

  // cell chain: left neighbor feeds insert, right neighbor feeds erase
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    oaie_cell #(
      .POS (g),
      .W   (W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (idx_w),
      .n          (n_w),
      .n_m1       (n_m1),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g]),
      .rd_word    (cell_rd[g])
    );
  end

  // at most one cell drives a nonzero read word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign read_value_c = (status_c == ST_OK) ? rd_or : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (ctl.en) begin
      fill_count <= CW'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= read_value_c;
      rsp.status     <= status_c;
      rsp.count      <= cnt_next[CNT_OUT_W-1:0];
      rsp.is_empty   <= (cnt_next == '0);
    end
  end

`include "ordered_array_insert_erase_top_macros.svh"

  `OAIE_ASSERT_NOW(a_cnt_bound, 1'b1, fill_count <= CW'(DEPTH), "fill count above depth")
  `OAIE_ASSERT_NOW(a_fail_zero, rsp.valid && (rsp.status != ST_OK), rsp.read_value == '0, "failed command returned data")
  `OAIE_ASSERT_NOW(a_stall_block, rsp.valid && !rsp.ready, !req.ready, "request taken while result stalled")
  `OAIE_ASSERT_NEXT(a_push_inc, accept && (req.command == CMD_PUSH) && (n_w < W'(DEPTH)), fill_count == $past(fill_count) + CW'(1), "push did not grow count")

endmodule
